/* rtl/core/calendar_date_difference_assert.svh */
// Assertion macros for the calendar date difference block.
// Included by the RTL modules that carry concurrent assertions; no dependencies.
`ifndef CALENDAR_DATE_DIFFERENCE_ASSERT_SVH
`define CALENDAR_DATE_DIFFERENCE_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define CDD_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define CDD_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/core/cdd_pkg.sv */
// Package for the calendar date difference block: widths, types and calendar tables.
// Used by cdd_date_ord and calendar_date_difference; no dependencies.
`default_nettype none

package cdd_pkg;

  localparam int unsigned MAX_YEAR = 4095;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int ORD_W   = 21;
  localparam int DIFF_W  = 22;
  localparam int ABS_W   = 21;

  // Reciprocals for division by 100 and 400 of values below 2**13.
  localparam int unsigned RECIP_100 = 5243;
  localparam int unsigned SHIFT_100 = 19;
  localparam int unsigned RECIP_400 = 5243;
  localparam int unsigned SHIFT_400 = 21;

  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [ORD_W-1:0]   ordinal_t;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
  } date_t;

  typedef struct packed {
    logic     ok;
    ordinal_t ord;
  } ord_t;

  localparam month_t MON_JAN = 4'd1;
  localparam month_t MON_FEB = 4'd2;
  localparam month_t MON_MAR = 4'd3;
  localparam month_t MON_APR = 4'd4;
  localparam month_t MON_MAY = 4'd5;
  localparam month_t MON_JUN = 4'd6;
  localparam month_t MON_JUL = 4'd7;
  localparam month_t MON_AUG = 4'd8;
  localparam month_t MON_SEP = 4'd9;
  localparam month_t MON_OCT = 4'd10;
  localparam month_t MON_NOV = 4'd11;
  localparam month_t MON_DEC = 4'd12;

  function automatic day_t month_len(month_t m, logic leap);
    day_t len;
    unique case (m)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(month_t m);
    logic [8:0] d;
    unique case (m)
      MON_JAN: d = 9'd0;
      MON_FEB: d = 9'd31;
      MON_MAR: d = 9'd59;
      MON_APR: d = 9'd90;
      MON_MAY: d = 9'd120;
      MON_JUN: d = 9'd151;
      MON_JUL: d = 9'd181;
      MON_AUG: d = 9'd212;
      MON_SEP: d = 9'd243;
      MON_OCT: d = 9'd273;
      MON_NOV: d = 9'd304;
      MON_DEC: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cdd_date_ord.sv */
// Three-stage pipeline that checks one date and maps it to its day ordinal.
// Depends on cdd_pkg.
`default_nettype none

module cdd_date_ord (
  input  wire            clk,
  input  cdd_pkg::date_t date,
  output cdd_pkg::ord_t  result
);
  import cdd_pkg::*;

  logic [12:0] y13;
  logic [12:0] y_c100;
  logic [12:0] y_c400;
  logic [25:0] p100;
  logic [25:0] p400;
  logic [25:0] p100c;
  logic [25:0] p400c;

  date_t      s1_date;
  logic [5:0] s1_q100;
  logic [3:0] s1_q400;
  logic [5:0] s1_qc100;
  logic [3:0] s1_qc400;

  logic [12:0] y1;
  logic [12:0] y1_p3;
  logic [12:0] m100;
  logic [12:0] m400;
  logic        leap;
  day_t        len;
  logic        valid;

  ordinal_t    s2_base;
  logic [10:0] s2_leaps;
  logic [8:0]  s2_doy;
  logic        s2_ok;

  assign y13    = {1'b0, date.year};
  assign y_c100 = y13 + 13'd99;
  assign y_c400 = y13 + 13'd399;
  assign p100   = 26'(y13) * 26'(RECIP_100);
  assign p400   = 26'(y13) * 26'(RECIP_400);
  assign p100c  = 26'(y_c100) * 26'(RECIP_100);
  assign p400c  = 26'(y_c400) * 26'(RECIP_400);

  always_ff @(posedge clk) begin
    s1_date  <= date;
    s1_q100  <= 6'(p100 >> SHIFT_100);
    s1_q400  <= 4'(p400 >> SHIFT_400);
    s1_qc100 <= 6'(p100c >> SHIFT_100);
    s1_qc400 <= 4'(p400c >> SHIFT_400);
  end

  assign y1    = {1'b0, s1_date.year};
  assign y1_p3 = y1 + 13'd3;
  assign m100  = 13'(s1_q100) * 13'd100;
  assign m400  = 13'(s1_q400) * 13'd400;
  assign leap  = ((s1_date.year[1:0] == 2'b00) && (y1 != m100)) || (y1 == m400);
  assign len   = month_len(s1_date.month, leap);
  assign valid = (s1_date.month >= MON_JAN) && (s1_date.month <= MON_DEC) &&
                 (32'(s1_date.year) <= 32'(MAX_YEAR)) &&
                 (s1_date.day != '0) && (s1_date.day <= len);

  always_ff @(posedge clk) begin
    s2_base  <= ORD_W'(s1_date.year) * ORD_W'(365);
    s2_leaps <= 11'(y1_p3 >> 2) - 11'(s1_qc100) + 11'(s1_qc400);
    s2_doy   <= days_before(s1_date.month) + 9'(s1_date.day) +
                9'(leap && (s1_date.month > MON_FEB));
    s2_ok    <= valid;
  end

  always_ff @(posedge clk) begin
    result.ord <= s2_base + ORD_W'(s2_leaps) + ORD_W'(s2_doy);
    result.ok  <= s2_ok;
  end

endmodule

`default_nettype wire

/* rtl/core/calendar_date_difference.sv */
// Top level of the calendar date difference block: two ordinal pipelines and the
// difference stage. Depends on cdd_pkg, cdd_date_ord and calendar_date_difference_assert.svh.
`default_nettype none
`include "calendar_date_difference_assert.svh"

// A transaction is taken at every clock edge where start is high and busy is low; busy
// is high only during reset, so one date pair can enter each cycle. Each transaction
// gives exactly one result: done is high for a single cycle while signed_days,
// abs_days and date_error hold the result. The result passes through the three stages
// of each ordinal pipeline and then the output register. The receiver cannot stall,
// so the result must be taken in the cycle that done marks.
module calendar_date_difference (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  cdd_pkg::day_t                    start_day,
  input  cdd_pkg::month_t                  start_month,
  input  cdd_pkg::year_t                   start_year,
  input  cdd_pkg::day_t                    end_day,
  input  cdd_pkg::month_t                  end_month,
  input  cdd_pkg::year_t                   end_year,
  output logic                             done,
  output logic signed [cdd_pkg::DIFF_W-1:0] signed_days,
  output logic [cdd_pkg::ABS_W-1:0]        abs_days,
  output logic                             date_error
);
  import cdd_pkg::*;

  date_t start_date;
  date_t end_date;
  ord_t  start_ord;
  ord_t  end_ord;

  logic [2:0]               vld;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] neg_diff;
  logic [ABS_W-1:0]         mag;
  logic                     ok;

  assign busy       = rst;
  assign start_date = '{day: start_day, month: start_month, year: start_year};
  assign end_date   = '{day: end_day, month: end_month, year: end_year};

  cdd_date_ord u_start_ord (
    .clk    (clk),
    .date   (start_date),
    .result (start_ord)
  );

  cdd_date_ord u_end_ord (
    .clk    (clk),
    .date   (end_date),
    .result (end_ord)
  );

  assign diff     = DIFF_W'(end_ord.ord) - DIFF_W'(start_ord.ord);
  assign neg_diff = DIFF_W'(start_ord.ord) - DIFF_W'(end_ord.ord);
  assign mag      = diff[DIFF_W-1] ? neg_diff[ABS_W-1:0] : diff[ABS_W-1:0];
  assign ok       = start_ord.ok && end_ord.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[1:0], start && !busy};
      done <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    signed_days <= ok ? diff : '0;
    abs_days    <= ok ? mag : '0;
    date_error  <= !ok;
  end

  `CDD_ASSERT_RST(a_latency, clk, rst, (start && !busy) |-> ##4 done,
                  "result strobe missing four cycles after a transaction")
  `CDD_ASSERT_RST(a_err_zero, clk, rst,
                  (done && date_error) |-> (signed_days == '0 && abs_days == '0),
                  "invalid date gave nonzero days")
  `CDD_ASSERT_RST(a_abs_match, clk, rst,
                  done |-> (abs_days == (signed_days[DIFF_W-1] ? ABS_W'(-signed_days)
                                                               : signed_days[ABS_W-1:0])),
                  "abs_days does not match signed_days")
  `CDD_ASSERT_ALL(a_reset_quiet, clk, rst |=> (!done && vld == '0),
                  "result strobe after reset")

endmodule

`default_nettype wire

/* sim/calendar_date_difference_tb.sv */
// Self-checking testbench for calendar_date_difference: directed date pairs, then random pairs.
// Results are checked against typed expected values or an in-bench Gregorian day-count predictor; depends on cdd_pkg.
`default_nettype none

module calendar_date_difference_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PAIRS = 1150;
  localparam int NUM_PHASES = 4;

  typedef struct packed {
    date_t first;
    date_t second;
  } date_pair_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] signed_days;
    logic [ABS_W-1:0]         abs_days;
    logic                     date_error;
  } span_t;

  typedef struct packed {
    date_pair_t pair;
    logic       typed;
    span_t      span;
  } dated_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  day_t start_day = '0;
  month_t start_month = '0;
  year_t start_year = '0;
  day_t end_day = '0;
  month_t end_month = '0;
  year_t end_year = '0;
  logic done;
  logic signed [DIFF_W-1:0] signed_days;
  logic [ABS_W-1:0] abs_days;
  logic date_error;

  span_t pending_spans[$];
  dated_row_t directed_rows[$];
  int mismatches = 0;
  int cycle_count = 0;

  calendar_date_difference uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .start_day(start_day),
    .start_month(start_month),
    .start_year(start_year),
    .end_day(end_day),
    .end_month(end_month),
    .end_year(end_year),
    .done(done),
    .signed_days(signed_days),
    .abs_days(abs_days),
    .date_error(date_error)
  );

  always #5 clk = ~clk;

  function automatic logic leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned m, logic leap);
    case (m)
      MON_FEB: return leap ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      default: return 31;
    endcase
  endfunction

  // Day count from the start of year zero; returns 0 when the date does not exist.
  function automatic logic day_number(input int unsigned d, input int unsigned m,
                                      input int unsigned y, output int unsigned num);
    logic leap;
    int unsigned k;
    num = 0;
    leap = leap_year(y);
    if (m < MON_JAN || m > MON_DEC || y > MAX_YEAR) return 1'b0;
    if (d < 1 || d > month_length(m, leap)) return 1'b0;
    num = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
    for (k = 32'(MON_JAN); k < m; k++) num += month_length(k, leap);
    return 1'b1;
  endfunction

  function automatic span_t predict_span(date_pair_t p);
    span_t s;
    int unsigned from_num;
    int unsigned to_num;
    logic from_ok;
    logic to_ok;
    int diff;
    from_ok = day_number(32'(p.first.day), 32'(p.first.month), 32'(p.first.year), from_num);
    to_ok = day_number(32'(p.second.day), 32'(p.second.month), 32'(p.second.year), to_num);
    s = '0;
    if (!(from_ok && to_ok)) begin
      s.date_error = 1'b1;
    end else begin
      diff = int'(to_num) - int'(from_num);
      s.signed_days = diff[DIFF_W-1:0];
      s.abs_days = ABS_W'((diff < 0) ? -diff : diff);
    end
    return s;
  endfunction

  function automatic date_t random_date_in(int unsigned lo, int unsigned hi);
    date_t dt;
    dt.year = YEAR_W'($urandom_range(hi, lo));
    dt.month = ($urandom_range(5) == 0) ? MON_FEB
             : MONTH_W'($urandom_range(32'(MON_DEC), 32'(MON_JAN)));
    dt.day = DAY_W'($urandom_range(month_length(32'(dt.month), leap_year(32'(dt.year))), 1));
    return dt;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    int unsigned sel;
    int unsigned lo;
    int unsigned hi;
    sel = $urandom_range(99);
    if (sel < 12) begin
      p.first.month = MONTH_W'($urandom());
      p.first.year = YEAR_W'($urandom());
      p.second.month = MONTH_W'($urandom());
      p.second.year = YEAR_W'($urandom());
      p.first.day = DAY_W'($urandom_range(31));
      p.second.day = DAY_W'($urandom_range(31));
      return p;
    end
    if (sel < 35) begin
      lo = 100 * $urandom_range(40);
      p.first = random_date_in(lo, lo);
    end else begin
      p.first = random_date_in(0, MAX_YEAR);
    end
    lo = (p.first.year > 3) ? p.first.year - 3 : 0;
    hi = (p.first.year + 3 > MAX_YEAR) ? MAX_YEAR : p.first.year + 3;
    if (sel < 40) p.second = p.first;
    else if (sel < 75) p.second = random_date_in(lo, hi);
    else p.second = random_date_in(0, MAX_YEAR);
    if (sel >= 94) begin
      if ($urandom_range(1)) p.second.day = DAY_W'($urandom_range(31, 29));
      else p.first.month = MONTH_W'($urandom_range(15, 13));
    end
    if ($urandom_range(1)) {p.first, p.second} = {p.second, p.first};
    return p;
  endfunction

  task automatic put_fields(date_pair_t p);
    start_day <= p.first.day;
    start_month <= p.first.month;
    start_year <= p.first.year;
    end_day <= p.second.day;
    end_month <= p.second.month;
    end_year <= p.second.year;
  endtask

  task automatic send_pair(date_pair_t p, logic typed, span_t typed_span);
    start <= 1'b1;
    put_fields(p);
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_spans = {pending_spans, (typed ? typed_span : predict_span(p))};
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    put_fields(random_pair());
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_spans.size() != 0);
  endtask

  task automatic add_row(int sd, int sm, int sy, int ed, int em, int ey,
                         logic typed, int days, logic err);
    dated_row_t r;
    r.pair.first.day = DAY_W'(sd);
    r.pair.first.month = MONTH_W'(sm);
    r.pair.first.year = YEAR_W'(sy);
    r.pair.second.day = DAY_W'(ed);
    r.pair.second.month = MONTH_W'(em);
    r.pair.second.year = YEAR_W'(ey);
    r.typed = typed;
    r.span.signed_days = DIFF_W'(days);
    r.span.abs_days = ABS_W'((days < 0) ? -days : days);
    r.span.date_error = err;
    directed_rows = {directed_rows, r};
  endtask

  always @(posedge clk) begin
    span_t want;
    if (!rst && done === 1'b1) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected result transaction: signed_days %0d", signed_days);
        mismatches++;
      end else begin
        want = pending_spans.pop_front();
        if (signed_days !== want.signed_days) begin
          $error("signed_days: expected %0d, got %0d", want.signed_days, signed_days);
          mismatches++;
        end
        if (abs_days !== want.abs_days) begin
          $error("abs_days: expected %0d, got %0d", want.abs_days, abs_days);
          mismatches++;
        end
        if (date_error !== want.date_error) begin
          $error("date_error: expected %0b, got %0b", want.date_error, date_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int idle_pct[NUM_PHASES];
    int phase;
    int i;
    idle_pct = '{0, 47, 0, 11};

    add_row(1, MON_JAN, 2000, 1, MON_JAN, 2000, 1'b1, 0, 1'b0);
    add_row(1, MON_JAN, 2000, 2, MON_JAN, 2000, 1'b1, 1, 1'b0);
    add_row(2, MON_JAN, 2000, 1, MON_JAN, 2000, 1'b1, -1, 1'b0);
    add_row(1, MON_JAN, 0, 1, MON_JAN, 1, 1'b1, 366, 1'b0);
    add_row(1, MON_JAN, 1, 1, MON_JAN, 2, 1'b1, 365, 1'b0);
    add_row(28, MON_FEB, 1900, 1, MON_MAR, 1900, 1'b1, 1, 1'b0);
    add_row(28, MON_FEB, 2000, 1, MON_MAR, 2000, 1'b1, 2, 1'b0);
    add_row(29, MON_FEB, 2000, 29, MON_FEB, 2000, 1'b1, 0, 1'b0);
    add_row(29, MON_FEB, 1900, 1, MON_JAN, 2000, 1'b1, 0, 1'b1);
    add_row(1, MON_JAN, 2001, 29, MON_FEB, 2001, 1'b1, 0, 1'b1);
    add_row(29, MON_FEB, 2004, 1, MON_MAR, 2004, 1'b1, 1, 1'b0);
    add_row(1, MON_JAN, 2020, 31, MON_APR, 2020, 1'b1, 0, 1'b1);
    add_row(0, MON_MAY, 2020, 1, MON_MAY, 2020, 1'b1, 0, 1'b1);
    add_row(1, 0, 2020, 1, MON_JAN, 2020, 1'b1, 0, 1'b1);
    add_row(1, MON_JAN, 2020, 1, 13, 2020, 1'b1, 0, 1'b1);
    add_row(31, 15, 4095, 1, MON_JAN, 1, 1'b1, 0, 1'b1);
    add_row(0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1);
    add_row(1, MON_JAN, 0, 31, MON_DEC, 4095, 1'b0, 0, 1'b0);
    add_row(31, MON_DEC, 4095, 1, MON_JAN, 0, 1'b0, 0, 1'b0);
    add_row(31, MON_DEC, 4095, 31, MON_DEC, 4095, 1'b1, 0, 1'b0);
    add_row(31, MON_JAN, 1, 1, MON_FEB, 1, 1'b1, 1, 1'b0);
    add_row(30, MON_JUN, 1999, 1, MON_JUL, 1999, 1'b1, 1, 1'b0);
    add_row(31, MON_DEC, 1999, 1, MON_JAN, 2000, 1'b1, 1, 1'b0);
    add_row(15, MON_AUG, 1947, 26, MON_JAN, 1950, 1'b0, 0, 1'b0);
    add_row(1, MON_DEC, 2024, 1, MON_NOV, 2024, 1'b1, -30, 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_pair(directed_rows[r].pair, directed_rows[r].typed, directed_rows[r].span);
    drain_results();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      for (i = 0; i < RANDOM_PAIRS / NUM_PHASES; i++) begin
        send_pair(random_pair(), 1'b0, '0);
        if ($urandom_range(99) < idle_pct[phase]) idle_cycles($urandom_range(4, 1));
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
